FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define SALA_ASSERT_NOW(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define SALA_ASSERT_NEXT(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/sala_pkg.sv
// ----------------------------------------------------------------------------
// sala_pkg
// Types and constants of the size-aware LRU cache tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sala_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 40;
    localparam int SIZE_W      = 32;
    localparam int KEY_W       = 64;
    localparam int STAT_W      = 2;
    localparam int EVC_W       = 7;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(1048576);
    localparam logic [APB_AW-1:0] ADDR_CAP    = APB_AW'(0);
    localparam logic              CMD_ACCESS  = 1'b0;
    localparam logic              CMD_REMOVE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_ZERO   = 2'd1,
        STAT_BYPASS = 2'd2,
        STAT_ABSENT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_FROM_PREV,
        OP_FROM_NEXT,
        OP_LOAD,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   size;
    } t_cell_data;

endpackage

`default_nettype wire

FILE: hdl/sala_if.sv
// ----------------------------------------------------------------------------
// sala_if
// Request and response channels of the cache tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface sala_req_if;
    import sala_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] object_size;
    modport source (output valid, command, key, object_size, input ready);
    modport sink   (input valid, command, key, object_size, output ready);
endinterface

interface sala_rsp_if;
    import sala_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [STAT_W-1:0] status;
    logic [EVC_W-1:0]  evicted_count;
    logic [CAP_W-1:0]  used_bytes_after;
    modport source (output valid, hit, status, evicted_count, used_bytes_after, input ready);
    modport sink   (input valid, hit, status, evicted_count, used_bytes_after, output ready);
endinterface

`default_nettype wire

FILE: hdl/sala_cell.sv
// ----------------------------------------------------------------------------
// sala_cell
// One place of the recency list: holds a key and a size, compares the key.
// ----------------------------------------------------------------------------
`default_nettype none

module sala_cell import sala_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_op            i_op,
    input  t_cell_data          i_prev,
    input  t_cell_data          i_next,
    input  t_cell_data          i_new,
    input  logic [KEY_BITS-1:0] i_key,
    output t_cell_data          o_data,
    output logic                o_match
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [SIZE_W-1:0]   r_size;
    t_cell_data          n_data;

    always_comb begin
        n_data = '{valid: r_valid, key: r_key, size: r_size};
        case (i_op)
            OP_HOLD:      n_data = '{valid: r_valid, key: r_key, size: r_size};
            OP_FROM_PREV: n_data = i_prev;
            OP_FROM_NEXT: n_data = i_next;
            OP_LOAD:      n_data = i_new;
            OP_CLEAR:     n_data.valid = 1'b0;
            default:      n_data = '{valid: r_valid, key: r_key, size: r_size};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_data.key;
        r_size <= n_data.size;
    end

    assign o_data  = '{valid: r_valid, key: r_key, size: r_size};
    assign o_match = r_valid && (r_key == i_key);

endmodule

`default_nettype wire

FILE: hdl/sala_apb.sv
// ----------------------------------------------------------------------------
// sala_apb
// Register port holding the cache capacity in bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sala_apb import sala_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CAP_W-1:0]  o_cap
);

    logic [CAP_W-1:0] r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_CAP)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAP) ? APB_DW'(r_cap) : '0;
    assign o_cap  = r_cap;

endmodule

`default_nettype wire

FILE: hdl/size_aware_lru_cache.sv
// ----------------------------------------------------------------------------
// size_aware_lru_cache
// Byte-capacity LRU tracker built as a row of list cells, most recent first.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake       | word
//  i_req    | in        | valid / ready   | command, key, object_size
//  o_rsp    | out       | valid / ready   | hit, status, evicted_count, used_bytes_after
//  apb      | in        | psel / penable  | capacity_bytes at byte address 0
//
// An access word passes key match in all cells, list update, an eviction loop
// over the tail cell and result load. The full-table eviction on insert takes
// place within the list update. A remove of a resident key skips the eviction
// loop; a bypassed access and an absent remove go from key match to result load.
// Reset clears all cell valid bits at once; no clearing pass is needed.
// A new word is taken in the cycle after the previous one has reached the output
// register; a stalled output holds the block in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module size_aware_lru_cache import sala_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sala_req_if.sink          i_req,
    sala_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_EVICT  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    function automatic logic [CAP_W:0] sat_sub(input logic [CAP_W:0] a,
                                               input logic [SIZE_W-1:0] b);
        logic [CAP_W:0] bw;
        bw = (CAP_W+1)'(b);
        return (a >= bw) ? (a - bw) : '0;
    endfunction

    logic [CAP_W-1:0]    cap;
    t_state              r_state;
    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [SIZE_W-1:0]   r_size;
    logic                r_hit;
    logic [IDX_W-1:0]    r_idx;
    logic [SIZE_W-1:0]   r_old;
    t_status             r_status;
    logic [EVC_W-1:0]    r_evict;
    logic [CAP_W:0]      r_used;
    logic [CNT_W-1:0]    r_count;
    logic                r_oval;
    logic                r_ohit;
    t_status             r_ostat;
    logic [EVC_W-1:0]    r_oevc;
    logic [CAP_W-1:0]    r_oused;

    t_cell_data          cell_q [MAX_ENTRIES];
    t_cell_op            cell_op [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match;
    t_cell_data          new_data;
    logic                hit_v;
    logic [IDX_W-1:0]    idx_v;
    logic [SIZE_W-1:0]   old_v;
    logic [CNT_W-1:0]    cnt_m1;
    logic [IDX_W-1:0]    last_idx;
    logic [SIZE_W-1:0]   last_size;
    logic                evict_go;
    logic                oversize;

    sala_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cap   (cap)
    );

    assign new_data = '{valid: 1'b1, key: r_key, size: r_size};

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_cell_data prev_d;
        t_cell_data next_d;
        if (g == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid
            assign prev_d = cell_q[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_inner
            assign next_d = cell_q[g+1];
        end
        sala_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (cell_op[g]),
            .i_prev  (prev_d),
            .i_next  (next_d),
            .i_new   (new_data),
            .i_key   (r_key),
            .o_data  (cell_q[g]),
            .o_match (match[g])
        );
    end

    // Keys are unique among valid cells, so the match vector is one-hot or zero.
    always_comb begin
        hit_v = |match;
        idx_v = '0;
        old_v = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            idx_v = idx_v | (IDX_W'(i) & {IDX_W{match[i]}});
            old_v = old_v | (cell_q[i].size & {SIZE_W{match[i]}});
        end
    end

    assign cnt_m1    = r_count - CNT_W'(1);
    assign last_idx  = cnt_m1[IDX_W-1:0];
    assign last_size = cell_q[last_idx].size;
    assign evict_go  = (r_used > (CAP_W+1)'(cap)) && (r_count != '0);
    assign oversize  = CAP_W'(r_size) > cap;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            cell_op[i] = OP_HOLD;
            case (r_state)
                S_UPDATE: begin
                    if (r_cmd == CMD_REMOVE) begin
                        if (IDX_W'(i) >= r_idx) cell_op[i] = OP_FROM_NEXT;
                    end else if (i == 0) begin
                        cell_op[i] = OP_LOAD;
                    end else if (!r_hit || (IDX_W'(i) <= r_idx)) begin
                        cell_op[i] = OP_FROM_PREV;
                    end
                end
                S_EVICT: begin
                    if (evict_go && (IDX_W'(i) == last_idx)) cell_op[i] = OP_CLEAR;
                end
                default: cell_op[i] = OP_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && o_rsp.ready && (r_state != S_DONE)) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (r_cmd == CMD_REMOVE) begin
                        r_state <= hit_v ? S_UPDATE : S_DONE;
                    end else begin
                        r_state <= oversize ? S_DONE : S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_cmd == CMD_REMOVE) begin
                        r_used  <= sat_sub(r_used, r_old);
                        r_count <= cnt_m1;
                        r_state <= S_DONE;
                    end else begin
                        if (r_hit) begin
                            r_used <= sat_sub(r_used, r_old) + (CAP_W+1)'(r_size);
                        end else if (r_count == CNT_W'(MAX_ENTRIES)) begin
                            r_used <= sat_sub(r_used, cell_q[MAX_ENTRIES-1].size)
                                      + (CAP_W+1)'(r_size);
                        end else begin
                            r_used  <= r_used + (CAP_W+1)'(r_size);
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (evict_go) begin
                        r_used  <= sat_sub(r_used, last_size);
                        r_count <= cnt_m1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_oval || o_rsp.ready) begin
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd   <= i_req.command;
                r_key   <= i_req.key[KEY_BITS-1:0];
                r_size  <= i_req.object_size;
                r_evict <= '0;
            end
            S_LOOK: begin
                r_hit <= hit_v;
                r_idx <= idx_v;
                r_old <= old_v;
                if (r_cmd == CMD_REMOVE) begin
                    r_status <= hit_v ? STAT_OK : STAT_ABSENT;
                end else if (oversize) begin
                    r_status <= STAT_BYPASS;
                end else begin
                    r_status <= (r_size == '0) ? STAT_ZERO : STAT_OK;
                end
            end
            S_UPDATE: begin
                if ((r_cmd == CMD_ACCESS) && !r_hit && (r_count == CNT_W'(MAX_ENTRIES))) begin
                    r_evict <= EVC_W'(1);
                end
            end
            S_EVICT: begin
                if (evict_go) r_evict <= r_evict + EVC_W'(1);
            end
            S_DONE: begin
                if (!r_oval || o_rsp.ready) begin
                    r_ohit  <= r_hit;
                    r_ostat <= r_status;
                    r_oevc  <= r_evict;
                    r_oused <= r_used[CAP_W-1:0];
                end
            end
            default: r_evict <= r_evict;
        endcase
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_oval;
    assign o_rsp.hit              = r_ohit;
    assign o_rsp.status           = r_ostat;
    assign o_rsp.evicted_count    = r_oevc;
    assign o_rsp.used_bytes_after = r_oused;

endmodule

`default_nettype wire

FILE: hdl/sala_checker.sv
// ----------------------------------------------------------------------------
// sala_checker
// Port-level checks on the result words of the cache tracker.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sala_checker import sala_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic              i_hit,
    input logic [STAT_W-1:0] i_status,
    input logic [EVC_W-1:0]  i_evicted
);

    // A bypassed word changes nothing, so it evicts nothing.
    `SALA_ASSERT_NOW(a_bypass_no_evict, i_clk, i_rst_n, i_valid && (i_status == STAT_BYPASS), i_evicted == '0)
    // A remove of an absent key cannot report a hit.
    `SALA_ASSERT_NOW(a_absent_no_hit, i_clk, i_rst_n, i_valid && (i_status == STAT_ABSENT), !i_hit)
    // No word evicts more objects than the table holds.
    `SALA_ASSERT_NOW(a_evict_bound, i_clk, i_rst_n, i_valid, i_evicted <= EVC_W'(MAX_ENTRIES))
    // A stalled result word stays offered.
    `SALA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)

endmodule

bind size_aware_lru_cache sala_checker u_sala_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_hit     (o_rsp.hit),
    .i_status  (o_rsp.status),
    .i_evicted (o_rsp.evicted_count)
);

`default_nettype wire
